### rtl/core/mfrs_pkg.sv
package mfrs_pkg;

    localparam int MFRS_MAX_STARS = 1024;
    localparam int MFRS_FLUX_BITS = 32;
    localparam int MFRS_FRAC_BITS = 24;
    localparam int RATIO_W        = 48;
    localparam int CNT_W          = 11;

    typedef struct packed {
        logic signed [31:0] instr_flux;
        logic signed [31:0] synth_flux;
        logic               last_star;
    } t_mfrs_in;

    typedef struct packed {
        logic [RATIO_W-1:0] scale_factor;
        logic [CNT_W-1:0]   valid_count;
        logic [CNT_W-1:0]   star_count;
        logic               fallback_used;
        logic               capacity_overflow;
    } t_mfrs_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_SEL_INIT,
        ST_OUTER_RD,
        ST_INNER_RD,
        ST_INNER_CMP,
        ST_OUTER_END,
        ST_EMIT
    } t_mfrs_state;

endpackage

### rtl/core/median_flux_ratio_scale_core.sv
// a star with no ratio needs no divide; a star with a ratio holds busy through 80 divide
// steps in one restoring divider, then one memory write
// last star: after any divide, one setup state, then per candidate tried (at most n for n
// ratios): outer read, read and compare per ratio, outer end; then emit, direct if no ratio
// one request at a time; strobe comes in the same cycle that busy falls; receiver cannot stall
// synchronous active-low reset clears counters and control; ratio memory is not cleared
module median_flux_ratio_scale_core
    import mfrs_pkg::*;
#(
    parameter int MAX_STARS = MFRS_MAX_STARS,
    parameter int FLUX_BITS = MFRS_FLUX_BITS,
    parameter int FRAC_BITS = MFRS_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_mfrs_in  i_req,
    output logic      o_strobe,
    output t_mfrs_out o_res
);

    localparam int AW   = $clog2(MAX_STARS);
    localparam int CW   = AW + 1;
    localparam int NW   = FLUX_BITS + RATIO_W;
    localparam int STEPS = NW;
    localparam int SW   = $clog2(STEPS + 1);

    logic [RATIO_W-1:0] mem [MAX_STARS];
    logic [RATIO_W-1:0] r_rd;

    t_mfrs_state r_state, n_state;
    logic [CW-1:0] r_valid, n_valid, r_seen, n_seen;
    logic r_ovf, n_ovf, r_last, n_last;
    logic [FLUX_BITS-1:0] r_den, n_den;
    logic [NW-1:0] r_num, n_num;
    logic [FLUX_BITS:0] r_rem, n_rem;
    logic [RATIO_W-1:0] r_q, n_q;
    logic r_sat, n_sat;
    logic [SW-1:0] r_step, n_step;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_less, n_less, r_eq, n_eq;
    logic [RATIO_W-1:0] r_cand, n_cand, r_res_val, n_res_val;
    logic r_strobe, n_strobe;
    t_mfrs_out r_out, n_out;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] target;
    logic signed [FLUX_BITS-1:0] fi, fs;
    logic [FLUX_BITS:0] trial;

    assign fi = i_req.instr_flux[FLUX_BITS-1:0];
    assign fs = i_req.synth_flux[FLUX_BITS-1:0];
    assign target = r_valid >> 1;
    assign trial = {r_rem[FLUX_BITS-1:0], r_num[NW-1]};

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= r_sat ? {RATIO_W{1'b1}} : r_q;
        end
        r_rd <= mem[raddr];
    end

    always_comb begin
        n_state = r_state; n_valid = r_valid; n_seen = r_seen; n_ovf = r_ovf;
        n_last = r_last; n_den = r_den; n_num = r_num; n_rem = r_rem; n_q = r_q;
        n_sat = r_sat; n_step = r_step; n_i = r_i; n_j = r_j; n_less = r_less;
        n_eq = r_eq; n_cand = r_cand; n_res_val = r_res_val; n_strobe = 1'b0;
        n_out = r_out;
        we = 1'b0; waddr = r_valid[AW-1:0]; raddr = r_j[AW-1:0];
        busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_last = i_req.last_star;
                    n_state = i_req.last_star ? ST_SEL_INIT : ST_IDLE;
                    if (r_seen == CW'(MAX_STARS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_seen = r_seen + 1'b1;
                        if (fi > 0 && fs > 0) begin
                            n_den = fi;
                            n_num = NW'(fs) << FRAC_BITS;
                            n_rem = '0; n_q = '0; n_sat = 1'b0; n_step = '0;
                            n_state = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = trial - {1'b0, r_den};
                    n_q = {r_q[RATIO_W-2:0], 1'b1};
                    n_sat = r_sat | r_q[RATIO_W-1];
                end else begin
                    n_rem = trial;
                    n_q = {r_q[RATIO_W-2:0], 1'b0};
                    n_sat = r_sat | r_q[RATIO_W-1];
                end
                n_num = r_num << 1;
                n_step = r_step + 1'b1;
                if (r_step == SW'(NW - 1)) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                we = 1'b1;
                n_valid = r_valid + 1'b1;
                n_state = r_last ? ST_SEL_INIT : ST_IDLE;
            end
            ST_SEL_INIT: begin
                n_i = '0;
                if (r_valid == '0) begin
                    n_res_val = RATIO_W'(1) << FRAC_BITS;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_OUTER_RD;
                end
            end
            ST_OUTER_RD: begin
                raddr = r_i[AW-1:0];
                n_j = '0; n_less = '0; n_eq = '0;
                n_state = ST_INNER_RD;
            end
            ST_INNER_RD: begin
                if (r_j == '0) n_cand = r_rd;
                raddr = r_j[AW-1:0];
                n_state = ST_INNER_CMP;
            end
            ST_INNER_CMP: begin
                if (r_rd < r_cand) n_less = r_less + 1'b1;
                else if (r_rd == r_cand) n_eq = r_eq + 1'b1;
                n_j = r_j + 1'b1;
                n_state = (r_j + 1'b1 == r_valid) ? ST_OUTER_END : ST_INNER_RD;
            end
            ST_OUTER_END: begin
                if (r_less <= target && target < r_less + r_eq) begin
                    n_res_val = r_cand;
                    n_state = ST_EMIT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = ST_OUTER_RD;
                end
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_out.scale_factor = r_res_val;
                n_out.valid_count = CNT_W'(r_valid);
                n_out.star_count = CNT_W'(r_seen);
                n_out.fallback_used = (r_valid == '0);
                n_out.capacity_overflow = r_ovf;
                n_valid = '0; n_seen = '0; n_ovf = 1'b0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_valid <= '0; r_seen <= '0; r_ovf <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_seen <= n_seen; r_ovf <= n_ovf;
            r_strobe <= n_strobe;
        end
        r_last <= n_last; r_den <= n_den; r_num <= n_num; r_rem <= n_rem; r_q <= n_q;
        r_sat <= n_sat; r_step <= n_step; r_i <= n_i; r_j <= n_j; r_less <= n_less;
        r_eq <= n_eq; r_cand <= n_cand; r_res_val <= n_res_val; r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_res = r_out;

`ifndef SYNTHESIS
    a_cnt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid <= r_seen) else $error("valid above seen");
    a_seen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CW'(MAX_STARS)) else $error("seen above capacity");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_state == ST_IDLE && r_valid == '0) else $error("bad strobe");
    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.valid_count == '0 |-> o_res.fallback_used)
        else $error("fallback");
`endif

endmodule
